/* src/lte_pkg.sv */
// Shared types, constants and digit helpers for the log timestamp decoder.
`timescale 1ns / 1ps
`default_nettype none
package lte_pkg;

  // Line window and byte counter
  localparam int WINDOW_BYTES = 32;
  localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
  localparam int COUNT_W      = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Line queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Config and divider widths
  localparam int START_W   = 41;
  localparam int TPM_W     = 32;
  localparam int DIVISOR_W = TPM_W + 4;
  localparam int EPOCH_W   = 64;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_W     = START_W;

  // Zone search span in ISO mode
  localparam int ZONE_FIRST = 19;
  localparam int ZONE_LAST  = ((WINDOW_BYTES < 32) ? WINDOW_BYTES : 32) - 1;

  // Characters
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef enum logic [1:0] {
    FMT_COMPACT = 2'd0,
    FMT_ISO     = 2'd1,
    FMT_TICKS   = 2'd2,
    FMT_NONE    = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_START  = 2'd1,
    CFG_TICKS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    fmt_t               fmt;
    logic [START_W-1:0] start;
    logic [TPM_W-1:0]   tpm;
  } lte_cfg_t;

  typedef struct packed {
    logic [WINDOW_BYTES-1:0][7:0] window;
    logic [COUNT_W-1:0]           len;
  } lte_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } lte_qctl_t;

  // Byte value minus '0', no digit check
  function automatic logic signed [8:0] dig(input logic [7:0] b);
    return $signed({1'b0, b}) - $signed({1'b0, CH_ZERO});
  endfunction

  function automatic logic signed [12:0] two_digits(input logic [7:0] a, input logic [7:0] b);
    logic signed [12:0] ta;
    logic signed [12:0] tb;
    ta = 13'(dig(a));
    tb = 13'(dig(b));
    return ta * 13'sd10 + tb;
  endfunction

  function automatic logic signed [19:0] four_digits(input logic [7:0] a, input logic [7:0] b,
                                                     input logic [7:0] c, input logic [7:0] d);
    logic signed [19:0] ta;
    logic signed [19:0] tb;
    logic signed [19:0] tc;
    logic signed [19:0] td;
    ta = 20'(dig(a));
    tb = 20'(dig(b));
    tc = 20'(dig(c));
    td = 20'(dig(d));
    return ta * 20'sd1000 + tb * 20'sd100 + tc * 20'sd10 + td;
  endfunction

endpackage
`default_nettype wire

/* src/log_timestamp_to_epoch.sv */
// Top level: config registers, byte front end, line queue and decode back end.
// Input takes one byte beat per cycle; in_stall rises only while the two-line queue is full.
// After the end-of-line beat, date modes step through the date-math states and tick mode waits
// on the 64-step restoring divider; invalid lines go straight to the result register.
// A line occupies the back end until its result is registered, so short lines back-to-back queue up behind it.
// Synchronous active-low reset clears counters, queue, sequencer and config to defaults.
`timescale 1ns / 1ps
`default_nettype none
module log_timestamp_to_epoch (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [lte_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_line_byte,
  input  logic                               in_end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lte_pkg::EPOCH_W-1:0] out_epoch_cs,
  output logic                               out_stamp_valid
);
  import lte_pkg::*;

  lte_cfg_t   cfg_r;
  lte_cfg_t   cfg_nxt;
  lte_entry_t push_entry;
  lte_entry_t pop_entry;
  lte_qctl_t  qctl;

  // Config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORMAT: cfg_nxt.fmt   = fmt_t'(cfg_wdata[1:0]);
        CFG_START:  cfg_nxt.start = cfg_wdata[START_W-1:0];
        CFG_TICKS:  cfg_nxt.tpm   = cfg_wdata[TPM_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt   <= FMT_NONE;
      cfg_r.start <= '1;
      cfg_r.tpm   <= TPM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = qctl.full;

  lte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_line_byte   (in_line_byte),
    .in_end_of_line (in_end_of_line),
    .push           (qctl.push),
    .entry          (push_entry)
  );

  lte_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qctl.push),
    .wdata (push_entry),
    .pop   (qctl.pop),
    .rdata (pop_entry),
    .full  (qctl.full),
    .empty (qctl.empty)
  );

  lte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_entry         (pop_entry),
    .q_empty         (qctl.empty),
    .q_pop           (qctl.pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_epoch_cs    (out_epoch_cs),
    .out_stamp_valid (out_stamp_valid)
  );

endmodule
`default_nettype wire

/* src/lte_front.sv */
// Front end: collects line bytes into the window and hands finished lines to the queue.
`timescale 1ns / 1ps
`default_nettype none
module lte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_line_byte,
  input  logic                in_end_of_line,
  output logic                push,
  output lte_pkg::lte_entry_t entry
);
  import lte_pkg::*;

  logic [WINDOW_BYTES-1:0][7:0] window_r;
  logic [WINDOW_BYTES-1:0][7:0] window_nxt;
  logic [COUNT_W-1:0]           count_r;
  logic [COUNT_W-1:0]           count_nxt;
  logic [COUNT_W-1:0]           count_inc;
  logic                         accept;

  assign accept    = in_valid && !in_stall;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  // Window write and saturating length
  always_comb begin
    window_nxt = window_r;
    count_nxt  = count_r;
    if (accept) begin
      if (7'(count_r) < 7'(WINDOW_BYTES)) begin
        window_nxt[count_r[WIN_IDX_W-1:0]] = in_line_byte;
      end
      count_nxt = in_end_of_line ? '0 : count_inc;
    end
  end

  // The last beat of a line goes out together with its own byte
  assign push         = accept && in_end_of_line;
  assign entry.window = window_nxt;
  assign entry.len    = count_inc;

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/lte_queue.sv */
// Short line queue between the front end and the decode sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lte_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lte_pkg::lte_entry_t wdata,
  input  logic                pop,
  output lte_pkg::lte_entry_t rdata,
  output logic                full,
  output logic                empty
);
  import lte_pkg::*;

  lte_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

/* src/lte_div.sv */
// Restoring divider, one quotient bit per cycle, for tick mode.
`timescale 1ns / 1ps
`default_nettype none
module lte_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lte_pkg::EPOCH_W-1:0]     dividend,
  input  logic [lte_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            busy,
  output logic                            done,
  output logic [lte_pkg::EPOCH_W-1:0]     quotient
);
  import lte_pkg::*;

  logic                   busy_r;
  logic                   busy_nxt;
  logic                   done_r;
  logic                   done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_CNT_W-1:0]   cnt_nxt;
  logic [DIVISOR_W:0]     rem_r;
  logic [DIVISOR_W:0]     rem_nxt;
  logic [EPOCH_W-1:0]     quo_r;
  logic [EPOCH_W-1:0]     quo_nxt;
  logic [DIVISOR_W-1:0]   dvs_r;
  logic [DIVISOR_W-1:0]   dvs_nxt;
  logic [DIVISOR_W:0]     trial;
  logic                   ge;

  // One shift-compare-subtract step
  assign trial = {rem_r[DIVISOR_W-1:0], quo_r[EPOCH_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, dvs_r} : trial;
      quo_nxt = {quo_r[EPOCH_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dvs_r  <= dvs_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

/* src/lte_back.sv */
// Back end: decode sequencer for date math and tick division, with the result register.
`timescale 1ns / 1ps
`default_nettype none
module lte_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lte_pkg::lte_cfg_t                 cfg,
  input  lte_pkg::lte_entry_t               q_entry,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lte_pkg::EPOCH_W-1:0] out_epoch_cs,
  output logic                              out_stamp_valid
);
  import lte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIELDS, S_ERA, S_CORR, S_DOE, S_DAYS, S_MUL, S_SUM, S_DIV, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  lte_entry_t             ent_r, ent_nxt;

  // Decoded fields
  logic signed [19:0]     year_r, year_nxt;
  logic signed [12:0]     mon_r, mon_nxt, day_r, day_nxt;
  logic signed [12:0]     hh_r, hh_nxt, mi_r, mi_nxt, ss_r, ss_nxt, cs_r, cs_nxt;
  logic signed [12:0]     zh_r, zh_nxt, zm_r, zm_nxt;
  logic                   zneg_r, zneg_nxt, zen_r, zen_nxt;

  // Date math pipeline registers
  logic [18:0]            x_r, x_nxt;
  logic [10:0]            q0_r, q0_nxt;
  logic [18:0]            mag_r, mag_nxt;
  logic                   dneg_r, dneg_nxt;
  logic [16:0]            d0_r, d0_nxt;
  logic signed [63:0]     hms_r, hms_nxt;
  logic signed [11:0]     era_r, era_nxt;
  logic [8:0]             yoe_r, yoe_nxt;
  logic signed [17:0]     doyq_r, doyq_nxt;
  logic signed [63:0]     zone_r, zone_nxt;
  logic signed [23:0]     doe_r, doe_nxt;
  logic signed [31:0]     era146_r, era146_nxt;
  logic signed [63:0]     tcs_r, tcs_nxt;
  logic signed [31:0]     days_r, days_nxt;
  logic signed [63:0]     dcs_r, dcs_nxt;
  logic [EPOCH_W-1:0]     res_r, res_nxt;
  logic                   ok_r, ok_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [EPOCH_W-1:0]     out_epoch_r, out_epoch_nxt;
  logic                   out_ok_r, out_ok_nxt;

  // Field decode of the line in ent_r
  logic signed [19:0]     f_year;
  logic signed [12:0]     f_mon, f_day, f_hh, f_mi, f_ss, f_cs, f_zh, f_zm;
  logic                   f_zfound, f_zneg, f_zen, f_date_ok, f_tick_ok, f_all_hex;
  logic [COUNT_W-1:0]     f_zpos;
  logic [EPOCH_W-1:0]     f_ticks;
  logic [3:0]             f_nib;
  logic [7:0]             f_c;

  // Divider
  logic                   div_start, div_busy, div_done;
  logic [DIVISOR_W-1:0]   div_dvs;
  logic [EPOCH_W-1:0]     div_quo;

  // Date math scratch
  logic signed [19:0]     y_s, x_s, r400_s;
  logic [32:0]            q0_prod;
  logic signed [12:0]     mp_s;
  logic signed [19:0]     t153_s;
  logic [38:0]            d0_prod;
  logic [10:0]            eraq;
  logic [19:0]            rd5;
  logic [16:0]            dq;
  logic signed [63:0]     zmag;
  logic signed [19:0]     doy_s;
  logic [1:0]             yoe_c100;

  assign div_dvs = DIVISOR_W'({cfg.tpm, 3'b000}) + DIVISOR_W'({cfg.tpm, 1'b0});

  lte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (f_ticks),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Field extraction, zone search and hex decode
  always_comb begin
    f_zfound = 1'b0;
    f_zneg   = 1'b0;
    f_zpos   = '0;
    f_zh     = '0;
    f_zm     = '0;
    for (int i = ZONE_FIRST; i <= ZONE_LAST; i++) begin
      if (!f_zfound && (COUNT_W'(i) < ent_r.len) &&
          (ent_r.window[i] == CH_PLUS || ent_r.window[i] == CH_MINUS)) begin
        f_zfound = 1'b1;
        f_zpos   = COUNT_W'(i);
        f_zneg   = (ent_r.window[i] == CH_MINUS);
      end
    end
    for (int i = ZONE_FIRST; i <= WINDOW_BYTES - 5; i++) begin
      if (f_zpos == COUNT_W'(i)) begin
        f_zh = two_digits(ent_r.window[i+1], ent_r.window[i+2]);
        f_zm = two_digits(ent_r.window[i+3], ent_r.window[i+4]);
      end
    end
    f_zen = f_zfound && ((7'(f_zpos) + 7'd4) < 7'(ent_r.len)) &&
            ((7'(f_zpos) + 7'd4) < 7'(WINDOW_BYTES));

    f_year = four_digits(ent_r.window[0], ent_r.window[1], ent_r.window[2], ent_r.window[3]);
    if (cfg.fmt == FMT_ISO) begin
      f_mon     = two_digits(ent_r.window[5], ent_r.window[6]);
      f_day     = two_digits(ent_r.window[8], ent_r.window[9]);
      f_hh      = two_digits(ent_r.window[11], ent_r.window[12]);
      f_mi      = two_digits(ent_r.window[14], ent_r.window[15]);
      f_ss      = two_digits(ent_r.window[17], ent_r.window[18]);
      f_cs      = (ent_r.window[19] == CH_DOT) ?
                  two_digits(ent_r.window[20], ent_r.window[21]) : '0;
      f_date_ok = (ent_r.len >= COUNT_W'(31));
    end else begin
      f_mon     = two_digits(ent_r.window[4], ent_r.window[5]);
      f_day     = two_digits(ent_r.window[6], ent_r.window[7]);
      f_hh      = two_digits(ent_r.window[9], ent_r.window[10]);
      f_mi      = two_digits(ent_r.window[11], ent_r.window[12]);
      f_ss      = two_digits(ent_r.window[13], ent_r.window[14]);
      f_cs      = two_digits(ent_r.window[15], ent_r.window[16]);
      f_date_ok = (ent_r.len >= COUNT_W'(17)) &&
                  (ent_r.window[0] >= CH_ZERO) && (ent_r.window[0] <= CH_NINE);
    end

    // Sixteen hex digits, most significant first
    f_ticks   = '0;
    f_all_hex = 1'b1;
    for (int i = 0; i < 16; i++) begin
      f_c = ent_r.window[i];
      if (f_c >= CH_ZERO && f_c <= CH_NINE) begin
        f_nib = 4'(f_c - CH_ZERO);
      end else if (f_c >= CH_UA && f_c <= CH_UF) begin
        f_nib = 4'(f_c - CH_UA + 8'd10);
      end else if (f_c >= CH_LA && f_c <= CH_LF) begin
        f_nib = 4'(f_c - CH_LA + 8'd10);
      end else begin
        f_nib     = '0;
        f_all_hex = 1'b0;
      end
      f_ticks = {f_ticks[EPOCH_W-5:0], f_nib};
    end
    f_tick_ok = !cfg.start[START_W-1] && (ent_r.len >= COUNT_W'(16)) &&
                (cfg.tpm != '0) && f_all_hex;
  end

  // Date math, one step per state
  always_comb begin
    y_s     = (mon_r <= 13'sd2) ? year_r - 20'sd1 : year_r;
    x_s     = y_s + 20'sd102400;
    q0_prod = 33'(x_r) * 33'd10485;
    mp_s    = mon_r + ((mon_r > 13'sd2) ? -13'sd3 : 13'sd9);
    t153_s  = 20'(mp_s) * 20'sd153 + 20'sd2;
    d0_prod = 39'(mag_r) * 39'd838860;
    r400_s  = $signed({1'b0, x_r}) - $signed(20'(q0_r) * 20'd400);
    eraq    = q0_r + 11'(r400_s >= 20'sd400);
    rd5     = 20'(mag_r) - 20'(d0_r) * 20'd5;
    dq      = d0_r + 17'(rd5 >= 20'd5);
    zmag    = 64'(zh_r) * 64'sd360000 + 64'(zm_r) * 64'sd6000;
    doy_s   = 20'(doyq_r) + 20'(day_r) - 20'sd1;
    if (yoe_r >= 9'd300) begin
      yoe_c100 = 2'd3;
    end else if (yoe_r >= 9'd200) begin
      yoe_c100 = 2'd2;
    end else if (yoe_r >= 9'd100) begin
      yoe_c100 = 2'd1;
    end else begin
      yoe_c100 = 2'd0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ent_nxt    = ent_r;
    year_nxt   = year_r;
    mon_nxt    = mon_r;
    day_nxt    = day_r;
    hh_nxt     = hh_r;
    mi_nxt     = mi_r;
    ss_nxt     = ss_r;
    cs_nxt     = cs_r;
    zh_nxt     = zh_r;
    zm_nxt     = zm_r;
    zneg_nxt   = zneg_r;
    zen_nxt    = zen_r;
    x_nxt      = x_r;
    q0_nxt     = q0_r;
    mag_nxt    = mag_r;
    dneg_nxt   = dneg_r;
    d0_nxt     = d0_r;
    hms_nxt    = hms_r;
    era_nxt    = era_r;
    yoe_nxt    = yoe_r;
    doyq_nxt   = doyq_r;
    zone_nxt   = zone_r;
    doe_nxt    = doe_r;
    era146_nxt = era146_r;
    tcs_nxt    = tcs_r;
    days_nxt   = days_r;
    dcs_nxt    = dcs_r;
    res_nxt    = res_r;
    ok_nxt     = ok_r;
    q_pop      = 1'b0;
    div_start  = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    out_epoch_nxt = out_epoch_r;
    out_ok_nxt    = out_ok_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_entry;
          state_nxt = S_FIELDS;
        end
      end
      S_FIELDS: begin
        year_nxt = f_year;
        mon_nxt  = f_mon;
        day_nxt  = f_day;
        hh_nxt   = f_hh;
        mi_nxt   = f_mi;
        ss_nxt   = f_ss;
        cs_nxt   = f_cs;
        zh_nxt   = f_zh;
        zm_nxt   = f_zm;
        zneg_nxt = f_zneg;
        zen_nxt  = f_zen && (cfg.fmt == FMT_ISO);
        res_nxt  = '1;
        ok_nxt   = 1'b0;
        state_nxt = S_DONE;
        unique case (cfg.fmt) inside
          FMT_COMPACT, FMT_ISO: begin
            if (f_date_ok) begin
              state_nxt = S_ERA;
            end
          end
          FMT_TICKS: begin
            if (f_tick_ok) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ERA: begin
        // Offset year for floor(y/400); day-of-year numerator
        x_nxt    = x_s[18:0];
        dneg_nxt = t153_s < 20'sd0;
        mag_nxt  = (t153_s < 20'sd0) ? 19'(-t153_s) : 19'(t153_s);
        hms_nxt  = 64'(hh_r) * 64'sd360000 + 64'(mi_r) * 64'sd6000 +
                   64'(ss_r) * 64'sd100 + 64'(cs_r);
        state_nxt = S_CORR;
      end
      S_CORR: begin
        // Reciprocal quotient estimates, corrected in the next step
        q0_nxt    = 11'(q0_prod >> 22);
        d0_nxt    = 17'(d0_prod >> 22);
        state_nxt = S_DOE;
      end
      S_DOE: begin
        era_nxt   = $signed(12'(eraq)) - 12'sd256;
        yoe_nxt   = (r400_s >= 20'sd400) ? 9'(r400_s - 20'sd400) : 9'(r400_s);
        doyq_nxt  = dneg_r ? -$signed(18'(dq)) : $signed(18'(dq));
        zone_nxt  = !zen_r ? 64'sd0 : (zneg_r ? -zmag : zmag);
        state_nxt = S_DAYS;
      end
      S_DAYS: begin
        doe_nxt    = 24'(yoe_r) * 24'sd365 + 24'(yoe_r >> 2) - 24'(yoe_c100) + 24'(doy_s);
        era146_nxt = 32'(era_r) * 32'sd146097;
        tcs_nxt    = hms_r - zone_r;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        days_nxt  = era146_r + 32'(doe_r) - 32'sd719468;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        dcs_nxt   = 64'(days_r) * 64'sd8640000;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cfg.fmt == FMT_TICKS) begin
          if (div_done) begin
            res_nxt   = EPOCH_W'(cfg.start) + div_quo;
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          res_nxt   = dcs_r + tcs_r;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_epoch_nxt = res_r;
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_epoch_r <= out_epoch_nxt;
      out_ok_r    <= out_ok_nxt;
      ent_r       <= ent_nxt;
      year_r      <= year_nxt;
      mon_r       <= mon_nxt;
      day_r       <= day_nxt;
      hh_r        <= hh_nxt;
      mi_r        <= mi_nxt;
      ss_r        <= ss_nxt;
      cs_r        <= cs_nxt;
      zh_r        <= zh_nxt;
      zm_r        <= zm_nxt;
      zneg_r      <= zneg_nxt;
      zen_r       <= zen_nxt;
      x_r         <= x_nxt;
      q0_r        <= q0_nxt;
      mag_r       <= mag_nxt;
      dneg_r      <= dneg_nxt;
      d0_r        <= d0_nxt;
      hms_r       <= hms_nxt;
      era_r       <= era_nxt;
      yoe_r       <= yoe_nxt;
      doyq_r      <= doyq_nxt;
      zone_r      <= zone_nxt;
      doe_r       <= doe_nxt;
      era146_r    <= era146_nxt;
      tcs_r       <= tcs_nxt;
      days_r      <= days_nxt;
      dcs_r       <= dcs_nxt;
      res_r       <= res_nxt;
      ok_r        <= ok_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_epoch_cs    = $signed(out_epoch_r);
  assign out_stamp_valid = out_ok_r;

`ifndef SYNTHESIS
  a_invalid_is_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_ok_r) |-> (out_epoch_r == '1))
    else $error("invalid stamp without -1 epoch");
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
      div_busy |-> (state_r == S_DIV))
    else $error("divider running outside its wait state");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |-> (state_r == S_IDLE && !q_empty))
    else $error("line taken while sequencer busy");
`endif

endmodule
`default_nettype wire
